// ----- sv/lfu_pkg.sv -----
// shared types and constants for the lfu page replacement core
// no dependencies; imported by lfu_search, lfu_page_replacement_core and tb_top
package lfu_pkg;

  localparam int FRAMES     = 16;
  localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OCC_W      = $clog2(FRAMES + 1);
  localparam int PAGE_W     = 8;
  localparam int COUNT_BITS = 16;
  localparam int FAULT_W    = 32;
  localparam int CFG_W      = 5;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [FAULT_W-1:0]    FAULT_MAX = '1;
  localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(16);

  typedef struct packed {
    logic [PAGE_W-1:0]     page;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  // outcome of one pass over the resident frames
  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [COUNT_BITS-1:0] hit_count;
    logic                  min_valid;
    logic [IDX_W-1:0]      min_idx;
    logic [COUNT_BITS-1:0] min_count;
    logic [PAGE_W-1:0]     min_page;
  } search_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_UPDATE = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_APPEND = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

endpackage

// ----- sv/lfu_search.sv -----
// streaming hit and least-count search over frame entries read from memory
// depends on lfu_pkg
module lfu_search (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      vld,
  input  logic [lfu_pkg::IDX_W-1:0] idx,
  input  lfu_pkg::entry_t           entry,
  input  logic [lfu_pkg::PAGE_W-1:0] page,
  output lfu_pkg::search_t          res
);
  import lfu_pkg::*;

  logic match;
  logic new_min;

  assign match   = vld && !res.hit && (entry.page == page);
  // strict less-than keeps the oldest frame on equal counts
  assign new_min = vld && (!res.min_valid || (entry.count < res.min_count));

  always_ff @(posedge clk) begin
    if (rst || start) begin
      res.hit       <= 1'b0;
      res.min_valid <= 1'b0;
    end else begin
      if (match) begin
        res.hit       <= 1'b1;
        res.hit_idx   <= idx;
        res.hit_count <= entry.count;
      end
      if (new_min) begin
        res.min_valid <= 1'b1;
        res.min_idx   <= idx;
        res.min_count <= entry.count;
        res.min_page  <= entry.page;
      end
    end
  end

endmodule

// ----- sv/lfu_page_replacement_core.sv -----
// lfu page replacement with oldest-first tie break, frames kept in one memory
// depends on lfu_pkg and lfu_search
// a transaction reads the resident frames one at a time through the single read port
//   of the frame memory, and an eviction also shifts the frames behind the victim
// throughput: one transaction at a time, the next once the last result is registered
// reset: synchronous active-high rst empties the frames, zeroes the fault total and
//   sets the frame limit to 16; frame memory itself is not cleared
module lfu_page_replacement_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lfu_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lfu_pkg::PAGE_W-1:0]   page,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic                         evicted_valid,
  output logic [lfu_pkg::PAGE_W-1:0]   evicted_page,
  output logic [lfu_pkg::FAULT_W-1:0]  fault_total
);
  import lfu_pkg::*;

  // control and bookkeeping
  state_t               state;
  logic [CFG_W-1:0]     frames_in_use;
  logic [OCC_W-1:0]     occ;        // resident frame count
  logic [FAULT_W-1:0]   faults;
  logic [PAGE_W-1:0]    page_q;
  logic [OCC_W-1:0]     ptr;        // next read address of a scan or shift
  logic                 rd_pend;    // read data valid this cycle
  logic [IDX_W-1:0]     rd_idx;     // address behind rd_data
  logic                 hit_q;
  logic                 evv_q;
  logic [PAGE_W-1:0]    evp_q;

  // frame memory, one read and one write port
  entry_t               mem [FRAMES];
  entry_t               rd_data;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;

  search_t              srch;
  logic                 accept;
  logic                 out_free;
  logic [OCC_W-1:0]     limit;
  logic                 full;
  logic [OCC_W-1:0]     last;       // occ - 1
  logic [OCC_W-1:0]     after_min;  // first frame behind the victim
  logic                 last_rd;
  entry_t               fresh;
  logic [COUNT_BITS-1:0] hit_inc;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // out-of-range limits clamp into 1..FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      limit = OCC_W'(1);
    end else if (32'(frames_in_use) > FRAMES) begin
      limit = OCC_W'(FRAMES);
    end else begin
      limit = OCC_W'(frames_in_use);
    end
  end

  // a lowered limit below occupancy still counts as full
  assign full      = (occ >= limit);
  assign last      = occ - OCC_W'(1);
  assign after_min = OCC_W'(srch.min_idx) + OCC_W'(1);
  assign last_rd   = rd_pend && (rd_idx == last[IDX_W-1:0]);
  assign hit_inc   = (srch.hit_count == COUNT_MAX) ? srch.hit_count
                                                   : srch.hit_count + COUNT_BITS'(1);
  assign fresh.page  = page_q;
  assign fresh.count = COUNT_BITS'(1);

  // memory port control; reads always run ahead of writes, so no entry
  // is read and written in the same pass at once
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = fresh;
    case (state)
      S_IDLE: begin
        if (accept && occ != '0) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      S_SCAN: begin
        rd_en = (ptr < occ);
      end
      S_UPDATE: begin
        if (srch.hit) begin
          wr_en         = 1'b1;
          wr_addr       = srch.hit_idx;
          wr_data.page  = page_q;
          wr_data.count = hit_inc;
        end else if (!full) begin
          wr_en   = 1'b1;
          wr_addr = occ[IDX_W-1:0];
        end else if (after_min < occ) begin
          rd_en   = 1'b1;
          rd_addr = after_min[IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        // move the frame just read one place toward the front
        rd_en = (ptr < occ);
        if (rd_pend) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx - IDX_W'(1);
          wr_data = rd_data;
        end
      end
      S_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = last[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  lfu_search u_search (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .vld   ((state == S_SCAN) && rd_pend),
    .idx   (rd_idx),
    .entry (rd_data),
    .page  (page_q),
    .res   (srch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frames_in_use <= CFG_RESET;
      occ           <= '0;
      faults        <= '0;
      rd_pend       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            page_q <= page;
            if (occ == '0) begin
              // nothing resident, skip the scan
              rd_pend <= 1'b0;
              state   <= S_UPDATE;
            end else begin
              ptr     <= OCC_W'(1);
              rd_pend <= 1'b1;
              rd_idx  <= '0;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_pend <= (ptr < occ);
          if (ptr < occ) begin
            ptr    <= ptr + OCC_W'(1);
            rd_idx <= ptr[IDX_W-1:0];
          end
          if (last_rd) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          rd_pend <= 1'b0;
          if (srch.hit) begin
            hit_q <= 1'b1;
            evv_q <= 1'b0;
            evp_q <= '0;
            state <= S_DONE;
          end else begin
            hit_q <= 1'b0;
            if (faults != FAULT_MAX) begin
              faults <= faults + FAULT_W'(1);
            end
            if (!full) begin
              occ   <= occ + OCC_W'(1);
              evv_q <= 1'b0;
              evp_q <= '0;
              state <= S_DONE;
            end else begin
              evv_q <= 1'b1;
              evp_q <= srch.min_page;
              if (after_min < occ) begin
                ptr     <= after_min + OCC_W'(1);
                rd_pend <= 1'b1;
                rd_idx  <= after_min[IDX_W-1:0];
                state   <= S_SHIFT;
              end else begin
                // victim is the newest frame, overwrite in place
                state <= S_APPEND;
              end
            end
          end
        end
        S_SHIFT: begin
          rd_pend <= (ptr < occ);
          if (ptr < occ) begin
            ptr    <= ptr + OCC_W'(1);
            rd_idx <= ptr[IDX_W-1:0];
          end
          if (last_rd) begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // result waits here until the output register is free
          if (out_free) begin
            out_valid     <= 1'b1;
            hit           <= hit_q;
            evicted_valid <= evv_q;
            evicted_page  <= evp_q;
            fault_total   <= faults;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // occupancy never runs past the memory depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= FRAMES)
    else $error("occupancy above frame count");

  // a delivered transaction never reports both a hit and an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("hit with eviction");

  // the scan never writes the frame memory
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !wr_en)
    else $error("write during scan");

  // fault total only moves up
  a_fault_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> faults >= $past(faults))
    else $error("fault total decreased");

  // an eviction is only chosen when the frames are full
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && !srch.hit && !full) |=> (state == S_DONE) && !evv_q)
    else $error("eviction with free frame");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for lfu_page_replacement_core: directed corners, a hot page, random traffic
// and a long output hold-off, every transaction checked against an in-bench lfu model
// depends on lfu_pkg and the core rtl only
module tb_top;
  import lfu_pkg::*;

  localparam int HALF_PERIOD       = 1;
  localparam int RESET_CYCLES      = 9;
  // cycle limit of the runaway guard, sized for a run in which every transaction evicts
  localparam int CYCLE_LIMIT       = 400_000;
  // drain time after the last result, sized for a worst case evicting transaction with 16 frames
  localparam int DRAIN_CYCLES      = 48;
  localparam int HOLD_CYCLES       = 400;
  localparam int HOLD_ITEMS        = 24;
  localparam int HOT_HITS          = 40;
  localparam int PRINT_CAP         = 40;
  localparam int ITEMS_PER_SETTING = 190;
  localparam int FULL_RANGE_PCT    = 20;
  localparam int HOT_PAGE_PCT      = 20;

  localparam logic [CFG_W-1:0] CAP_ZERO      = '0;
  localparam logic [CFG_W-1:0] CAP_ONE       = CFG_W'(1);
  localparam logic [CFG_W-1:0] CAP_THREE     = CFG_W'(3);
  localparam logic [CFG_W-1:0] CAP_FIELD_MAX = '1;

  // frame limits for the random settings, mostly rising since occupancy never drops
  localparam int RANDOM_CAPS [8] = '{2, 6, 9, 12, 16, 31, 0, 1};
  // idling per pair of settings: none, sender only, receiver only, both
  localparam int SEND_IDLE_PCT [4] = '{0, 46, 0, 37};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 46, 37};

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } lfu_outcome_t;

  // dut ports
  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [PAGE_W-1:0]  page;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               hit;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FAULT_W-1:0] fault_total;

  // traffic shaping knobs
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;

  // bookkeeping
  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;

  // model state: frames in insertion order, oldest at index 0
  logic [CFG_W-1:0]      frame_cap;
  logic [PAGE_W-1:0]     model_page  [FRAMES];
  logic [COUNT_BITS-1:0] model_count [FRAMES];
  int                    model_resident;
  logic [FAULT_W-1:0]    model_faults;
  lfu_outcome_t          outcomes_due [$];

  lfu_page_replacement_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .page          (page),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

  always #HALF_PERIOD clk = ~clk;

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver side: random stalls, plus a long hold-off counted down here
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // one line per mismatch; printing is capped so a broken core cannot flood the log
  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    if (mismatches < PRINT_CAP)
      $display("tb: mismatch on %s, expected %0h, got %0h, cycle %0d",
               what, want, got, cycle_count);
    mismatches++;
  endtask

  // lfu step: hit bumps the count (saturating), miss appends or evicts the lowest
  // count, oldest first on ties; a limit below occupancy evicts and frees nothing
  function automatic lfu_outcome_t next_lfu_outcome(input logic [PAGE_W-1:0] pg);
    lfu_outcome_t res;
    int           lim;
    int           victim;
    res = '0;
    lim = int'(frame_cap);
    if (lim < 1) lim = 1;
    if (lim > FRAMES) lim = FRAMES;
    for (int i = 0; i < model_resident; i++) begin
      if (model_page[i] == pg) begin
        res.hit = 1'b1;
        if (model_count[i] != COUNT_MAX) model_count[i]++;
        break;
      end
    end
    if (!res.hit) begin
      if (model_faults != FAULT_MAX) model_faults++;
      if (model_resident < lim) begin
        model_page[model_resident]  = pg;
        model_count[model_resident] = COUNT_BITS'(1);
        model_resident++;
      end else begin
        victim = 0;
        for (int i = 1; i < model_resident; i++)
          if (model_count[i] < model_count[victim]) victim = i;
        res.evicted_valid = 1'b1;
        res.evicted_page  = model_page[victim];
        for (int i = victim; i + 1 < model_resident; i++) begin
          model_page[i]  = model_page[i + 1];
          model_count[i] = model_count[i + 1];
        end
        model_page[model_resident - 1]  = pg;
        model_count[model_resident - 1] = COUNT_BITS'(1);
      end
    end
    res.fault_total = model_faults;
    return res;
  endfunction

  // result side: each output transaction against the oldest outstanding outcome
  always @(posedge clk) begin : check_outcome
    lfu_outcome_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("transaction with nothing outstanding", 64'(0), 64'(0));
      end else begin
        want = outcomes_due.pop_front();
        if (hit !== want.hit) report_mismatch("hit", 64'(want.hit), 64'(hit));
        if (evicted_valid !== want.evicted_valid)
          report_mismatch("evicted_valid", 64'(want.evicted_valid), 64'(evicted_valid));
        if (evicted_page !== want.evicted_page)
          report_mismatch("evicted_page", 64'(want.evicted_page), 64'(evicted_page));
        if (fault_total !== want.fault_total)
          report_mismatch("fault_total", 64'(want.fault_total), 64'(fault_total));
      end
    end
  end

  // sender side: optional idle gap, then hold the page until the core takes it;
  // valid stays up when the next page follows straight away
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    page     <= pg;
    do @(posedge clk); while (in_stall);
    outcomes_due.push_back(next_lfu_outcome(pg));
  endtask

  // frame limit writes only once every outstanding transaction has come back
  task automatic write_frame_limit(input logic [CFG_W-1:0] cap);
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    frame_cap = cap;
    cfg_we    <= 1'b0;
  endtask

  // mostly a small working set with a few hot pages, some full-range noise
  function automatic logic [PAGE_W-1:0] pick_page(input int base, input int span);
    int r;
    r = $urandom_range(99);
    if (r < FULL_RANGE_PCT) return PAGE_W'($urandom_range(255));
    if (r < FULL_RANGE_PCT + HOT_PAGE_PCT) return PAGE_W'(base + $urandom_range(2));
    return PAGE_W'(base + $urandom_range(span - 1));
  endfunction

  // limit of zero, lowest count eviction, oldest-first tie break, page extremes,
  // limit lowered below occupancy, limit field above the frame count
  task automatic test_frame_limit_corners;
    idle_pct  = 0;
    stall_pct = 0;
    write_frame_limit(CAP_ZERO);
    send_page(8'd5);
    send_page(8'd5);
    send_page(8'd7);
    send_page(8'd7);
    write_frame_limit(CAP_THREE);
    send_page(8'd255);
    send_page(8'd0);
    send_page(8'd255);
    send_page(8'd128);
    send_page(8'd1);
    send_page(8'd1);
    send_page(8'd9);
    write_frame_limit(CAP_ONE);
    send_page(8'd10);
    send_page(8'd1);
    write_frame_limit(CAP_FIELD_MAX);
    send_page(8'd77);
  endtask

  // one page hit many times under a limit below occupancy; its high count keeps
  // it resident while a fresh page evicts one of the low-count frames instead
  task automatic test_hot_page;
    idle_pct  = 0;
    stall_pct = 0;
    write_frame_limit(CAP_ONE);
    send_page(8'd200);
    repeat (HOT_HITS) send_page(8'd200);
    send_page(8'd201);
    send_page(8'd200);
  endtask

  // random traffic over several frame limits and all four idling mixes
  task automatic test_random_traffic;
    int base;
    int span;
    for (int k = 0; k < 8; k++) begin
      idle_pct  = SEND_IDLE_PCT[k / 2];
      stall_pct = RECV_STALL_PCT[k / 2];
      write_frame_limit(CFG_W'(RANDOM_CAPS[k]));
      base = $urandom_range(255);
      span = $urandom_range(26, 4);
      repeat (ITEMS_PER_SETTING) send_page(pick_page(base, span));
    end
  endtask

  // receiver holds off for a long stretch while pages keep coming, so the core
  // fills up and has to stall its input
  task automatic test_output_holdoff;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left <= HOLD_CYCLES;
    repeat (HOLD_ITEMS) send_page(pick_page(40, 20));
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    page      = '0;
    // model after reset: empty frames, no faults, full frame limit
    frame_cap      = CFG_RESET;
    model_resident = 0;
    model_faults   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_frame_limit_corners();
    test_hot_page();
    test_random_traffic();
    test_output_holdoff();

    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lfu_pkg.sv
sv/lfu_search.sv
sv/lfu_page_replacement_core.sv
tb/tb_top.sv
